// ----- sv/fbq_pkg.sv -----
// Shared constants, codes and result record for the bounded FIFO queue.
`default_nettype none

package fbq_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int CAP_W = 9;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam int CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_ENQ   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam int VALUE_W = 32;
   localparam int OCC_W   = 9;

   localparam int REQ_FIELDS_W = CMD_W + VALUE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + 3 * VALUE_W + OCC_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic                      is_empty;
      logic [OCC_W-1:0]          occupancy;
      logic signed [VALUE_W-1:0] rear_value;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] popped_value;
      logic [STATUS_W-1:0]       status;
   } rsp_fields_type;

endpackage

`default_nettype wire

// ----- sv/fbq_ram.sv -----
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module fbq_ram #(
   parameter int DEPTH = fbq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [AW-1:0]                    wr_addr,
   input  wire logic signed [fbq_pkg::VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]                    rd_addr,
   output logic signed [fbq_pkg::VALUE_W-1:0]    rd_data
);

   logic signed [fbq_pkg::VALUE_W-1:0] mem [DEPTH];
   logic signed [fbq_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/fbq_ctrl.sv -----
// Queue control: pointers, count, capacity, cached front and rear, pending result.
`default_nettype none

module fbq_ctrl #(
   parameter int DEPTH = fbq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [fbq_pkg::CAP_W-1:0]          csr_wdata,
   input  wire logic                               accept,
   input  wire logic [fbq_pkg::CMD_W-1:0]          cmd,
   input  wire logic signed [fbq_pkg::VALUE_W-1:0] push_value,
   output logic                                    item_ready,
   output logic                                    pend_valid,
   input  wire logic                               pend_take,
   output fbq_pkg::rsp_fields_type                 pend_fields,
   output logic                                    wr_en,
   output logic [AW-1:0]                           wr_addr,
   output logic signed [fbq_pkg::VALUE_W-1:0]      wr_data,
   output logic [AW-1:0]                           rd_addr,
   input  wire logic signed [fbq_pkg::VALUE_W-1:0] rd_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int WW = (CW > fbq_pkg::CAP_W) ? CW : fbq_pkg::CAP_W;

   logic [AW-1:0]                      rp_ff, rp_in, wp_ff, wp_in, rp_next, wp_next;
   logic [CW-1:0]                      count_ff, count_in;
   logic [fbq_pkg::CAP_W-1:0]          cap_ff, cap_in;
   logic signed [fbq_pkg::VALUE_W-1:0] front_ff, front_in, rear_ff, rear_in, cur_front;
   logic                               fetch_ff, fetch_in;
   logic                               pend_valid_ff, pend_valid_in;
   logic [fbq_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic signed [fbq_pkg::VALUE_W-1:0] popped_ff, popped_in;
   logic [WW-1:0]                      count_w, cap_w;
   logic                               is_full, is_zero;

   assign cur_front = fetch_ff ? rd_data : front_ff;
   assign count_w   = WW'(count_ff);
   assign cap_w     = (WW'(cap_ff) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(cap_ff);
   assign is_full   = count_w >= cap_w;
   assign is_zero   = count_ff == '0;
   assign rp_next   = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_next   = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   assign cap_in     = csr_we ? csr_wdata : cap_ff;
   assign item_ready = !pend_valid_ff || pend_take;
   assign rd_addr    = rp_next;
   assign wr_addr    = wp_ff;
   assign wr_data    = push_value;

   always_comb begin
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      front_in      = cur_front;
      rear_in       = rear_ff;
      fetch_in      = 1'b0;
      wr_en         = 1'b0;
      status_in     = status_ff;
      popped_in     = popped_ff;
      pend_valid_in = pend_valid_ff && !pend_take;
      if (accept) begin
         pend_valid_in = 1'b1;
         status_in     = fbq_pkg::ST_OK;
         popped_in     = '0;
         case (cmd)
            fbq_pkg::CMD_ENQ: begin
               if (is_full) begin
                  status_in = fbq_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wp_in    = wp_next;
                  count_in = count_ff + 1'b1;
                  rear_in  = push_value;
                  if (is_zero) begin
                     front_in = push_value;
                  end
               end
            end
            fbq_pkg::CMD_DEQ: begin
               if (is_zero) begin
                  status_in = fbq_pkg::ST_EMPTY;
               end else begin
                  popped_in = cur_front;
                  rp_in     = rp_next;
                  count_in  = count_ff - 1'b1;
                  fetch_in  = count_ff != CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff         <= '0;
         wp_ff         <= '0;
         count_ff      <= '0;
         cap_ff        <= fbq_pkg::CAP_RESET;
         fetch_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         fetch_ff      <= fetch_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff  <= front_in;
      rear_ff   <= rear_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
   end

   assign pend_valid = pend_valid_ff;

   always_comb begin
      pend_fields              = '0;
      pend_fields.status       = status_ff;
      pend_fields.popped_value = popped_ff;
      pend_fields.front_value  = is_zero ? '0 : cur_front;
      pend_fields.rear_value   = is_zero ? '0 : rear_ff;
      pend_fields.occupancy    = fbq_pkg::OCC_W'(count_w);
      pend_fields.is_empty     = is_zero;
   end

endmodule

`default_nettype wire

// ----- sv/bounded_fifo_queue.sv -----
// Bounded FIFO queue of signed 32-bit values held in a ring buffer memory.
// A result goes through the pending register, then the response register.
// Throughput: one transaction per cycle unless responses stall; the memory
// read of the next front entry after a dequeue feeds the following transaction.
// Reset (synchronous): pointers and count cleared, capacity set to 256;
// the entry store is not cleared and needs no clearing pass.
`default_nettype none

module bounded_fifo_queue #(
   parameter int DEPTH = fbq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [fbq_pkg::CAP_W-1:0]        csr_wdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // cmd, push_value
   input  wire logic [fbq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // status, popped_value, front_value, rear_value, occupancy, is_empty
   output logic [fbq_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int AW = $clog2(DEPTH);

   logic                               accept, item_ready, pend_valid, pend_take;
   fbq_pkg::rsp_fields_type            pend_fields, rsp_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr, rd_addr;
   logic signed [fbq_pkg::VALUE_W-1:0] wr_data, rd_data;
   logic [fbq_pkg::CMD_W-1:0]          req_cmd;
   logic signed [fbq_pkg::VALUE_W-1:0] req_value;

   assign req_cmd    = req_tdata[fbq_pkg::CMD_W-1:0];
   assign req_value  = req_tdata[fbq_pkg::REQ_FIELDS_W-1:fbq_pkg::CMD_W];
   assign req_tready = item_ready;
   assign accept     = req_tvalid && item_ready;
   assign pend_take  = pend_valid && (!rsp_valid_ff || rsp_tready);

   fbq_ram #(
      .DEPTH   (DEPTH),
      .AW      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fbq_ctrl #(
      .DEPTH       (DEPTH),
      .AW          (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .cmd         (req_cmd),
      .push_value  (req_value),
      .item_ready  (item_ready),
      .pend_valid  (pend_valid),
      .pend_take   (pend_take),
      .pend_fields (pend_fields),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   assign rsp_valid_in = pend_take || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_take) begin
         rsp_ff <= pend_fields;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = fbq_pkg::RSP_DATA_W'(rsp_ff);

   a_accept_pends: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_valid)
      else $error("accepted transaction left no pending result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_empty |->
         rsp_ff.front_value == '0 && rsp_ff.rear_value == '0)
      else $error("empty queue reports non-zero front or rear");

   a_status_popped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != fbq_pkg::ST_OK |-> rsp_ff.popped_value == '0)
      else $error("failed transaction reports a popped value");

   a_empty_on_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == fbq_pkg::ST_EMPTY |-> rsp_ff.is_empty)
      else $error("dequeue underflow on a non-empty queue");

endmodule

`default_nettype wire

// ----- verif/tb_bounded_fifo_queue.sv -----
// Self-checking testbench for the bounded FIFO queue: directed table, then random phases.
`default_nettype none

module tb_bounded_fifo_queue;

   localparam logic [fbq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 157;
   localparam int MAX_REPORTS = 10;

   typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_type;
   typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_type;

   typedef struct {
      row_kind_type                  kind;
      logic [fbq_pkg::CMD_W-1:0]     cmd;
      logic [fbq_pkg::VALUE_W-1:0]   value;
      bit                            checked;
      fbq_pkg::rsp_fields_type       exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [fbq_pkg::CAP_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [fbq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [fbq_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // queue shadow
   logic [fbq_pkg::VALUE_W-1:0] model_store [fbq_pkg::DEPTH_DEFAULT];
   int model_rd = 0;
   int model_wr = 0;
   int model_count = 0;
   int model_cap = int'(fbq_pkg::CAP_RESET);

   fbq_pkg::rsp_fields_type expected_rsp_q[$];
   stim_row_type directed_rows[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idling_on = 1'b1;

   bounded_fifo_queue dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic fbq_pkg::rsp_fields_type fifo_model_step(
      logic [fbq_pkg::CMD_W-1:0] op, logic [fbq_pkg::VALUE_W-1:0] val);
      fbq_pkg::rsp_fields_type r;
      int eff_cap;
      r = '0;
      eff_cap = (model_cap > fbq_pkg::DEPTH_DEFAULT) ? fbq_pkg::DEPTH_DEFAULT : model_cap;
      r.status = fbq_pkg::ST_OK;
      if (op == fbq_pkg::CMD_ENQ) begin
         if (model_count >= eff_cap) begin
            r.status = fbq_pkg::ST_FULL;
         end else begin
            model_store[model_wr] = val;
            model_wr = (model_wr + 1) % fbq_pkg::DEPTH_DEFAULT;
            model_count++;
         end
      end else if (op == fbq_pkg::CMD_DEQ) begin
         if (model_count == 0) begin
            r.status = fbq_pkg::ST_EMPTY;
         end else begin
            r.popped_value = model_store[model_rd];
            model_rd = (model_rd + 1) % fbq_pkg::DEPTH_DEFAULT;
            model_count--;
         end
      end
      if (model_count != 0) begin
         r.front_value = model_store[model_rd];
         r.rear_value = model_store[(model_wr + fbq_pkg::DEPTH_DEFAULT - 1) %
                                    fbq_pkg::DEPTH_DEFAULT];
      end
      r.occupancy = model_count[fbq_pkg::OCC_W-1:0];
      r.is_empty = (model_count == 0);
      return r;
   endfunction

   function automatic string fmt_rsp(fbq_pkg::rsp_fields_type r);
      return $sformatf("status=%0d popped=%0d front=%0d rear=%0d occ=%0d empty=%0d",
                       r.status, r.popped_value, r.front_value, r.rear_value,
                       r.occupancy, r.is_empty);
   endfunction

   function automatic void report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH %s", msg);
   endfunction

   function automatic void add_row(row_kind_type kind, logic [fbq_pkg::CMD_W-1:0] cmd,
                                   logic [fbq_pkg::VALUE_W-1:0] value);
      stim_row_type row;
      row.kind = kind;
      row.cmd = cmd;
      row.value = value;
      row.checked = 1'b0;
      row.exp = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked(logic [fbq_pkg::CMD_W-1:0] cmd,
                                       logic [fbq_pkg::VALUE_W-1:0] value,
                                       logic [fbq_pkg::STATUS_W-1:0] st,
                                       logic [fbq_pkg::VALUE_W-1:0] pop,
                                       logic [fbq_pkg::VALUE_W-1:0] fr,
                                       logic [fbq_pkg::VALUE_W-1:0] re,
                                       int occ, bit emp);
      stim_row_type row;
      row.kind = ROW_ITEM;
      row.cmd = cmd;
      row.value = value;
      row.checked = 1'b1;
      row.exp.status = st;
      row.exp.popped_value = pop;
      row.exp.front_value = fr;
      row.exp.rear_value = re;
      row.exp.occupancy = occ[fbq_pkg::OCC_W-1:0];
      row.exp.is_empty = emp;
      directed_rows.push_back(row);
   endfunction

   // entered and left at a falling edge
   task automatic send_item(logic [fbq_pkg::CMD_W-1:0] cmd, logic [fbq_pkg::VALUE_W-1:0] val,
                            bit checked, fbq_pkg::rsp_fields_type exp);
      fbq_pkg::rsp_fields_type pred;
      int gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(fbq_pkg::REQ_DATA_W - fbq_pkg::REQ_FIELDS_W){1'b0}}, val, cmd};
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
      end
      pred = fifo_model_step(cmd, val);
      expected_rsp_q.push_back(checked ? exp : pred);
      @(negedge clock);
   endtask

   task automatic set_capacity(int cap);
      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap[fbq_pkg::CAP_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      model_cap = cap & ((1 << fbq_pkg::CAP_W) - 1);
   endtask

   function automatic logic [fbq_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [fbq_pkg::CMD_W-1:0] pick_cmd(mix_mode_type mode);
      int r;
      int enq_lim;
      int deq_lim;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            enq_lim = 90;
            deq_lim = 96;
         end
         MODE_DRAIN: begin
            enq_lim = 10;
            deq_lim = 90;
         end
         default: begin
            enq_lim = 45;
            deq_lim = 90;
         end
      endcase
      if (r < enq_lim)
         return fbq_pkg::CMD_ENQ;
      else if (r < deq_lim)
         return fbq_pkg::CMD_DEQ;
      else if (r < 98)
         return fbq_pkg::CMD_QUERY;
      else
         return CMD_UNUSED;
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      fbq_pkg::rsp_fields_type got;
      fbq_pkg::rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = fbq_pkg::rsp_fields_type'(rsp_tdata[fbq_pkg::RSP_FIELDS_W-1:0]);
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction: %s", fmt_rsp(got)));
         end else begin
            want = expected_rsp_q.pop_front();
            if (got.status !== want.status || got.popped_value !== want.popped_value ||
                got.front_value !== want.front_value || got.rear_value !== want.rear_value ||
                got.occupancy !== want.occupancy || got.is_empty !== want.is_empty)
               report_mismatch($sformatf("exp %s / got %s", fmt_rsp(want), fmt_rsp(got)));
         end
      end
   end

   initial begin
      int caps [PHASE_COUNT];
      mix_mode_type modes [PHASE_COUNT];
      int cap;
      logic [fbq_pkg::CMD_W-1:0] cmd;
      caps = '{256, 511, 3, 0, 1, 257, 2, 255, -1, -1, 256, -1};
      modes = '{MODE_FILL, MODE_FILL, MODE_MIXED, MODE_FILL, MODE_MIXED, MODE_FILL,
                MODE_DRAIN, MODE_FILL, MODE_MIXED, MODE_MIXED, MODE_FILL, MODE_DRAIN};

      // after reset, empty-queue cases, value extremes
      add_checked(fbq_pkg::CMD_QUERY, 32'h0, fbq_pkg::ST_OK, 0, 0, 0, 0, 1);
      add_checked(fbq_pkg::CMD_DEQ, 32'h0, fbq_pkg::ST_EMPTY, 0, 0, 0, 0, 1);
      add_checked(CMD_UNUSED, 32'h1234, fbq_pkg::ST_OK, 0, 0, 0, 0, 1);
      add_checked(fbq_pkg::CMD_ENQ, 32'h7FFF_FFFF, fbq_pkg::ST_OK, 0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
      add_checked(fbq_pkg::CMD_ENQ, 32'h8000_0000, fbq_pkg::ST_OK, 0,
                  32'h7FFF_FFFF, 32'h8000_0000, 2, 0);
      add_checked(fbq_pkg::CMD_QUERY, 32'hFFFF_FFFF, fbq_pkg::ST_OK, 0,
                  32'h7FFF_FFFF, 32'h8000_0000, 2, 0);
      add_checked(fbq_pkg::CMD_DEQ, 32'h0, fbq_pkg::ST_OK, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 1, 0);
      add_checked(fbq_pkg::CMD_DEQ, 32'h0, fbq_pkg::ST_OK, 32'h8000_0000, 0, 0, 0, 1);
      // zero capacity
      add_row(ROW_CAP, fbq_pkg::CMD_QUERY, 32'd0);
      add_checked(fbq_pkg::CMD_ENQ, 32'hFFFF_FFFF, fbq_pkg::ST_FULL, 0, 0, 0, 0, 1);
      // full queue, then capacity lowered below the count
      add_row(ROW_CAP, fbq_pkg::CMD_QUERY, 32'd2);
      add_checked(fbq_pkg::CMD_ENQ, 32'hFFFF_FFFF, fbq_pkg::ST_OK, 0,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
      add_checked(fbq_pkg::CMD_ENQ, 32'h0, fbq_pkg::ST_OK, 0, 32'hFFFF_FFFF, 32'h0, 2, 0);
      add_checked(fbq_pkg::CMD_ENQ, 32'h5555_5555, fbq_pkg::ST_FULL, 0,
                  32'hFFFF_FFFF, 32'h0, 2, 0);
      add_row(ROW_CAP, fbq_pkg::CMD_QUERY, 32'd1);
      add_checked(fbq_pkg::CMD_ENQ, 32'hAAAA_AAAA, fbq_pkg::ST_FULL, 0,
                  32'hFFFF_FFFF, 32'h0, 2, 0);
      add_checked(fbq_pkg::CMD_DEQ, 32'h0, fbq_pkg::ST_OK, 32'hFFFF_FFFF, 32'h0, 32'h0, 1, 0);
      add_checked(fbq_pkg::CMD_ENQ, 32'd9, fbq_pkg::ST_FULL, 0, 32'h0, 32'h0, 1, 0);
      add_checked(fbq_pkg::CMD_DEQ, 32'h0, fbq_pkg::ST_OK, 32'h0, 0, 0, 0, 1);
      add_row(ROW_ITEM, fbq_pkg::CMD_ENQ, 32'h1357_9BDF);
      // capacity above the depth
      add_row(ROW_CAP, fbq_pkg::CMD_QUERY, 32'd511);
      add_row(ROW_ITEM, fbq_pkg::CMD_ENQ, 32'h2468_ACE0);
      add_row(ROW_ITEM, fbq_pkg::CMD_QUERY, 32'h0);
      add_row(ROW_ITEM, fbq_pkg::CMD_DEQ, 32'h0);
      add_row(ROW_ITEM, fbq_pkg::CMD_DEQ, 32'h0);
      add_row(ROW_ITEM, fbq_pkg::CMD_DEQ, 32'h0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CAP)
            set_capacity(int'(directed_rows[i].value));
         else
            send_item(directed_rows[i].cmd, directed_rows[i].value,
                      directed_rows[i].checked, directed_rows[i].exp);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         cap = (caps[p] < 0) ? $urandom_range(0, 511) : caps[p];
         set_capacity(cap);
         if (p == PHASE_COUNT - 1)
            idling_on = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = pick_cmd(modes[p]);
            send_item(cmd, pick_value(), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- bounded_fifo_queue.f -----
sv/fbq_pkg.sv
sv/fbq_ram.sv
sv/fbq_ctrl.sv
sv/bounded_fifo_queue.sv
verif/tb_bounded_fifo_queue.sv
